@@ src/wpp_pkg.sv @@
// shared types, constants and helpers for the wav pcm16 mono stream parser
package wpp_pkg;

    // file and chunk tags, as they appear big-endian in the byte stream
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // size limits
    localparam logic [5:0]  MIN_FILE_BYTES = 6'd44;
    localparam logic [31:0] FMT_MIN_BYTES  = 32'd16;

    // byte positions inside the riff header
    localparam logic [5:0] POS_RIFF_LAST = 6'd3;
    localparam logic [5:0] POS_WAVE_LAST = 6'd11;

    // parse phase codes
    localparam logic [1:0] PH_RIFF = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_PAD  = 2'd3;

    // bit positions in the seen flags
    localparam int F_FMT   = 0;
    localparam int F_DATA  = 1;
    localparam int F_SHORT = 2;
    localparam int F_RIFF  = 3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SMALL    = 3'd1;
    localparam logic [2:0] ST_NOT_RIFF = 3'd2;
    localparam logic [2:0] ST_BAD_FMT  = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_FORMAT   = 3'd5;
    localparam logic [2:0] ST_RATE     = 3'd6;
    localparam logic [2:0] ST_EMPTY    = 3'd7;

    // result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // expected pcm format fields
    localparam logic [15:0] FMT_PCM     = 16'd1;
    localparam logic [15:0] CH_MONO     = 16'd1;
    localparam logic [15:0] BITS_PCM16  = 16'd16;

    // results caused by one input byte: an optional sample and an optional status
    typedef struct packed {
        logic        has_sample;
        logic [15:0] sample;
        logic        has_status;
        logic [2:0]  status;
        logic [31:0] rate;
        logic [30:0] total;
    } result_t;

    // little-endian size field held big-endian in the header shift register
    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

@@ src/wav_pcm16_mono_stream_parser.sv @@
// top level of the wav pcm16 mono stream parser
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------------
//  in      | in_valid  | in_stall  | data_byte, final_byte
//  out     | out_valid | out_stall | result_kind, sample_value, status_code,
//          |           |           | rate_hz, total_samples, end_of_run
//
// one byte is taken per clock while in_stall is low; the chunk walker updates its state in the cycle of the transfer
// results caused by a byte are registered into a two-entry result queue
// the final byte gives up to two results (sample then status); while out_stall is low, one per cycle
// in_stall rises only when the result queue holds two entries
// asynchronous active-low reset; after the final byte the walker returns to reset state
module wav_pcm16_mono_stream_parser
    import wpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic signed [15:0] sample_value,
    output logic [2:0]         status_code,
    output logic [31:0]        rate_hz,
    output logic [30:0]        total_samples,
    output logic               end_of_run
);

    logic        take;
    logic        full;
    logic        push;
    result_t     res;
    logic [15:0] sample_bits;

    // input transfer
    assign in_stall = full;
    assign take     = in_valid && !full;
    assign push     = take && (res.has_sample || res.has_status);

    // chunk walker
    wpp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .res        (res)
    );

    // result queue
    wpp_outq u_outq (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .entry         (res),
        .full          (full),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .sample_bits   (sample_bits),
        .status_code   (status_code),
        .rate_hz       (rate_hz),
        .total_samples (total_samples),
        .end_of_run    (end_of_run)
    );

    assign sample_value = $signed(sample_bits);

endmodule

@@ src/wpp_core.sv @@
// chunk walker: header checks, fmt capture, sample pairing and final status
module wpp_core
    import wpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output result_t     res
);

    logic [5:0]  pos_reg,     pos_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [63:0] hdr_reg,     hdr_next;
    logic [31:0] tag_reg,     tag_next;
    logic [31:0] left_reg,    left_next;
    logic [47:0] pfmt_reg,    pfmt_next;
    logic [31:0] prate_reg,   prate_next;
    logic [47:0] fmt_reg,     fmt_next;
    logic [31:0] rate_reg,    rate_next;
    logic [31:0] dbytes_reg,  dbytes_next;
    logic [3:0]  flags_reg,   flags_next;
    logic [8:0]  low_reg,     low_next;

    logic        commit_en;
    logic [31:0] commit_size;
    logic [31:0] commit_tag;
    logic [31:0] size_cur;
    logic [31:0] size_new;
    logic [31:0] off;
    logic [2:0]  status;

    // next state for one byte
    always_comb
    begin
        pos_next    = (pos_reg == MIN_FILE_BYTES) ? pos_reg : pos_reg + 6'd1;
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        pfmt_next   = pfmt_reg;
        prate_next  = prate_reg;
        fmt_next    = fmt_reg;
        rate_next   = rate_reg;
        dbytes_next = dbytes_reg;
        flags_next  = flags_reg;
        low_next    = low_reg;
        commit_en   = 1'b0;
        commit_size = 32'd0;
        commit_tag  = tag_reg;
        size_cur    = bswap32(hdr_reg[31:0]);
        size_new    = 32'd0;
        off         = size_cur - left_reg;
        res         = '0;

        case (phase_reg)
            PH_RIFF:
            begin
                hdr_next = {hdr_reg[55:0], data_byte};
                if (pos_reg == POS_RIFF_LAST)
                begin
                    tag_next = hdr_next[31:0];
                end
                if (pos_reg == POS_WAVE_LAST)
                begin
                    if (tag_reg == TAG_RIFF && hdr_next[31:0] == TAG_WAVE)
                    begin
                        flags_next[F_RIFF] = 1'b1;
                    end
                    tag_next   = 32'd0;
                    hdr_next   = 64'd0;
                    left_next  = 32'd0;
                    phase_next = PH_HDR;
                end
            end
            PH_HDR:
            begin
                hdr_next  = {hdr_reg[55:0], data_byte};
                left_next = left_reg + 32'd1;
                if (left_reg == 32'd7)
                begin
                    size_new   = bswap32(hdr_next[31:0]);
                    tag_next   = hdr_next[63:32];
                    commit_tag = hdr_next[63:32];
                    pfmt_next  = 48'd0;
                    prate_next = 32'd0;
                    low_next   = 9'd0;
                    if (size_new == 32'd0)
                    begin
                        commit_en = 1'b1;
                        left_next = 32'd0;
                    end
                    else
                    begin
                        left_next  = size_new;
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                // fmt fields land by offset within the chunk body
                if (tag_reg == TAG_FMT)
                begin
                    if (off < 32'd4)
                    begin
                        case (off[1:0])
                            2'd0:    pfmt_next[7:0]   = data_byte;
                            2'd1:    pfmt_next[15:8]  = data_byte;
                            2'd2:    pfmt_next[23:16] = data_byte;
                            default: pfmt_next[31:24] = data_byte;
                        endcase
                    end
                    else if (off < 32'd8)
                    begin
                        case (off[1:0])
                            2'd0:    prate_next[7:0]   = data_byte;
                            2'd1:    prate_next[15:8]  = data_byte;
                            2'd2:    prate_next[23:16] = data_byte;
                            default: prate_next[31:24] = data_byte;
                        endcase
                    end
                    else if (off == 32'd14)
                    begin
                        pfmt_next[39:32] = data_byte;
                    end
                    else if (off == 32'd15)
                    begin
                        pfmt_next[47:40] = data_byte;
                    end
                end
                else if (tag_reg == TAG_DATA)
                begin
                    // pair little-endian bytes into one sample
                    if (!off[0])
                    begin
                        low_next = {1'b1, data_byte};
                    end
                    else if (low_reg[8])
                    begin
                        res.has_sample = 1'b1;
                        res.sample     = {data_byte, low_reg[7:0]};
                        low_next       = 9'd0;
                    end
                end
                left_next = left_reg - 32'd1;
                if (left_next == 32'd0)
                begin
                    commit_en   = 1'b1;
                    commit_size = size_cur;
                    low_next    = 9'd0;
                    phase_next  = size_cur[0] ? PH_PAD : PH_HDR;
                end
            end
            default:
            begin
                left_next  = 32'd0;
                phase_next = PH_HDR;
            end
        endcase

        // chunk completes: commit fmt or data
        if (commit_en)
        begin
            if (commit_tag == TAG_FMT)
            begin
                if (commit_size < FMT_MIN_BYTES)
                begin
                    flags_next[F_SHORT] = 1'b1;
                end
                else
                begin
                    fmt_next           = pfmt_next;
                    rate_next          = prate_next;
                    flags_next[F_FMT]  = 1'b1;
                end
            end
            else if (commit_tag == TAG_DATA)
            begin
                dbytes_next        = commit_size;
                flags_next[F_DATA] = 1'b1;
            end
        end

        // final status, first failing check wins
        if (pos_next < MIN_FILE_BYTES)
        begin
            status = ST_SMALL;
        end
        else if (!flags_next[F_RIFF])
        begin
            status = ST_NOT_RIFF;
        end
        else if (flags_next[F_SHORT])
        begin
            status = ST_BAD_FMT;
        end
        else if (!flags_next[F_FMT] || !flags_next[F_DATA])
        begin
            status = ST_MISSING;
        end
        else if (fmt_next[15:0] != FMT_PCM || fmt_next[31:16] != CH_MONO
                 || fmt_next[47:32] != BITS_PCM16)
        begin
            status = ST_FORMAT;
        end
        else if (rate_next == 32'd0)
        begin
            status = ST_RATE;
        end
        else if (dbytes_next < 32'd2)
        begin
            status = ST_EMPTY;
        end
        else
        begin
            status = ST_OK;
        end

        res.has_status = final_byte;
        res.status     = final_byte ? status : ST_OK;
        res.rate       = final_byte ? rate_next : 32'd0;
        res.total      = final_byte ? dbytes_next[31:1] : 31'd0;
    end

    // state update, back to reset after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= PH_RIFF;
            hdr_reg    <= '0;
            tag_reg    <= '0;
            left_reg   <= '0;
            pfmt_reg   <= '0;
            prate_reg  <= '0;
            fmt_reg    <= '0;
            rate_reg   <= '0;
            dbytes_reg <= '0;
            flags_reg  <= '0;
            low_reg    <= '0;
        end
        else if (take)
        begin
            if (final_byte)
            begin
                pos_reg    <= '0;
                phase_reg  <= PH_RIFF;
                hdr_reg    <= '0;
                tag_reg    <= '0;
                left_reg   <= '0;
                pfmt_reg   <= '0;
                prate_reg  <= '0;
                fmt_reg    <= '0;
                rate_reg   <= '0;
                dbytes_reg <= '0;
                flags_reg  <= '0;
                low_reg    <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                phase_reg  <= phase_next;
                hdr_reg    <= hdr_next;
                tag_reg    <= tag_next;
                left_reg   <= left_next;
                pfmt_reg   <= pfmt_next;
                prate_reg  <= prate_next;
                fmt_reg    <= fmt_next;
                rate_reg   <= rate_next;
                dbytes_reg <= dbytes_next;
                flags_reg  <= flags_next;
                low_reg    <= low_next;
            end
        end
    end

    // header byte count stays below the eight header bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR) |-> (left_reg < 32'd8))
        else $error("chunk header count out of range");

    // riff header phase ends at byte eleven
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RIFF) |-> (pos_reg <= POS_WAVE_LAST))
        else $error("riff header phase overran");

    // a body always has bytes left to take
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (left_reg != 32'd0))
        else $error("chunk body with nothing left");

endmodule

@@ src/wpp_outq.sv @@
// two-entry result queue, unpacks sample and status into separate transfers
module wpp_outq
    import wpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     entry,
    output logic        full,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [15:0] sample_bits,
    output logic [2:0]  status_code,
    output logic [31:0] rate_hz,
    output logic [30:0] total_samples,
    output logic        end_of_run
);

    result_t     mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        sub_reg;
    result_t     head;
    logic        show_sample;
    logic        xfer;
    logic        last_item;
    logic        pop;

    // head entry and which of its results is shown
    always_comb
    begin
        head          = mem_reg[rd_ptr_reg];
        show_sample   = head.has_sample && !sub_reg;
        out_valid     = (count_reg != 2'd0);
        full          = (count_reg == 2'd2);
        result_kind   = show_sample ? KIND_SAMPLE : KIND_STATUS;
        sample_bits   = show_sample ? head.sample : 16'd0;
        status_code   = show_sample ? ST_OK : head.status;
        rate_hz       = show_sample ? 32'd0 : head.rate;
        total_samples = show_sample ? 31'd0 : head.total;
        end_of_run    = !show_sample;
        xfer          = out_valid && !out_stall;
        last_item     = !show_sample || !head.has_status;
        pop           = xfer && last_item;
        count_next    = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    // pointers, fill count and sub-item flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
                sub_reg    <= 1'b0;
            end
            else if (xfer)
            begin
                sub_reg <= 1'b1;
            end
        end
    end

    // fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result queue overflow");

    // sub-item flag only while the head holds both a sample and a status
    assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (count_reg != 2'd0 && head.has_sample && head.has_status))
        else $error("status half shown without a paired entry");

    // a sample with a status behind it is followed by that status
    assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && !sub_reg && head.has_sample && head.has_status) |=> sub_reg)
        else $error("status after sample lost");

endmodule

@@ test/tb_wav_pcm16_mono_stream_parser.sv @@
// testbench for the wav pcm16 mono stream parser: whole files byte by byte, results in order
module tb_wav_pcm16_mono_stream_parser;
    import wpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one result transfer as the parser presents it
    typedef struct {
        logic        kind;
        logic [15:0] sample;
        logic [2:0]  status;
        logic [31:0] rate;
        logic [30:0] total;
        logic        eor;
    } wav_result_t;

    // shapes of generated files
    typedef enum int {
        FILE_OK,
        FILE_SMALL,
        FILE_NOT_RIFF,
        FILE_SHORT_FMT,
        FILE_MISSING,
        FILE_FORMAT,
        FILE_ZERO_RATE,
        FILE_EMPTY,
        FILE_MULTI,
        FILE_TRUNC,
        FILE_NOISE
    } file_kind_t;

    localparam int          NUM_FILE_KINDS = 11;
    localparam logic [31:0] TAG_JUNK       = 32'h6a75_6e6b;

    // chunk walker predictor plus the store of results still owed by the parser
    class wav_parse_predictor;
        logic [31:0] pos;
        logic [1:0]  phase;
        logic [63:0] hdr;
        logic [31:0] tag;
        logic [32:0] left;
        logic [63:0] pend_fmt;
        logic [31:0] pend_rate;
        logic [63:0] fmt_fields;
        logic [31:0] rate;
        logic [31:0] data_len;
        logic [3:0]  flags;
        logic [8:0]  low;
        wav_result_t expected_results[$];
        int          errors;
        int          samples_seen;
        int          statuses_seen;
        logic [7:0]  codes_seen;

        function new();
            clear_parse();
            errors = 0;
            samples_seen = 0;
            statuses_seen = 0;
            codes_seen = '0;
        endfunction

        function void clear_parse();
            pos = '0;
            phase = PH_RIFF;
            hdr = '0;
            tag = '0;
            left = '0;
            pend_fmt = '0;
            pend_rate = '0;
            fmt_fields = '0;
            rate = '0;
            data_len = '0;
            flags = '0;
            low = '0;
        endfunction

        // owed results are kept in arrival order
        function void add_expected(input wav_result_t r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        // size field arrives little-endian at the bottom of the header shift
        function logic [31:0] chunk_len();
            return {hdr[7:0], hdr[15:8], hdr[23:16], hdr[31:24]};
        endfunction

        function void commit_chunk(input logic [31:0] len);
            if (tag == TAG_FMT)
            begin
                if (len < FMT_MIN_BYTES)
                    flags[F_SHORT] = 1'b1;
                else
                begin
                    fmt_fields = pend_fmt;
                    rate = pend_rate;
                    flags[F_FMT] = 1'b1;
                end
            end
            else if (tag == TAG_DATA)
            begin
                data_len = len;
                flags[F_DATA] = 1'b1;
            end
        endfunction

        // advance the walker by one accepted byte and queue what it causes
        function void accept_byte(input logic [7:0] b, input logic fin);
            logic [31:0] len;
            logic [31:0] off;
            logic [2:0]  st;
            wav_result_t r;
            if (phase == PH_RIFF)
            begin
                hdr = {hdr[55:0], b};
                if (pos == 32'd3)
                    tag = hdr[31:0];
                if (pos == 32'd11)
                begin
                    if (tag == TAG_RIFF && hdr[31:0] == TAG_WAVE)
                        flags[F_RIFF] = 1'b1;
                    tag = '0;
                    hdr = '0;
                    left = '0;
                    phase = PH_HDR;
                end
            end
            else if (phase == PH_HDR)
            begin
                hdr = {hdr[55:0], b};
                left = left + 33'd1;
                if (left >= 33'd8)
                begin
                    len = chunk_len();
                    tag = hdr[63:32];
                    pend_fmt = '0;
                    pend_rate = '0;
                    low = '0;
                    if (len == 32'd0)
                    begin
                        commit_chunk(32'd0);
                        left = '0;
                    end
                    else
                    begin
                        left = {1'b0, len};
                        phase = PH_BODY;
                    end
                end
            end
            else if (phase == PH_BODY)
            begin
                len = chunk_len();
                off = len - left[31:0];
                if (tag == TAG_FMT)
                begin
                    if (off < 32'd4)
                        pend_fmt = pend_fmt | (64'(b) << (off * 8));
                    else if (off < 32'd8)
                        pend_rate = pend_rate | (32'(b) << ((off - 32'd4) * 8));
                    else if (off == 32'd14 || off == 32'd15)
                        pend_fmt = pend_fmt | (64'(b) << (32 + (off - 32'd14) * 8));
                end
                else if (tag == TAG_DATA)
                begin
                    if (!off[0])
                        low = {1'b1, b};
                    else if (low[8])
                    begin
                        r = '{KIND_SAMPLE, {b, low[7:0]}, ST_OK, 32'd0, 31'd0, 1'b0};
                        add_expected(r);
                        low = '0;
                    end
                end
                left = left - 33'd1;
                if (left == 33'd0)
                begin
                    commit_chunk(len);
                    low = '0;
                    phase = len[0] ? PH_PAD : PH_HDR;
                end
            end
            else
            begin
                left = '0;
                phase = PH_HDR;
            end

            if (pos != 32'hFFFF_FFFF)
                pos = pos + 32'd1;

            // status on the last byte, first failing check wins
            if (fin)
            begin
                if (pos < MIN_FILE_BYTES)
                    st = ST_SMALL;
                else if (!flags[F_RIFF])
                    st = ST_NOT_RIFF;
                else if (flags[F_SHORT])
                    st = ST_BAD_FMT;
                else if (!flags[F_FMT] || !flags[F_DATA])
                    st = ST_MISSING;
                else if (fmt_fields[15:0] != FMT_PCM || fmt_fields[31:16] != CH_MONO ||
                         fmt_fields[47:32] != BITS_PCM16)
                    st = ST_FORMAT;
                else if (rate == 32'd0)
                    st = ST_RATE;
                else if (data_len < 32'd2)
                    st = ST_EMPTY;
                else
                    st = ST_OK;
                r = '{KIND_STATUS, 16'd0, st, rate, data_len[31:1], 1'b1};
                add_expected(r);
                clear_parse();
            end
        endfunction

        function void compare(input string name, input logic [31:0] want,
                              input logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic kind, input logic [15:0] sample,
                                   input logic [2:0] status, input logic [31:0] r_hz,
                                   input logic [30:0] total, input logic eor);
            wav_result_t w;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, kind %0b status %0d sample %0h",
                         $realtime, kind, status, sample);
                errors++;
                return;
            end
            w = expected_results.pop_front();
            compare("result_kind", 32'(w.kind), 32'(kind));
            compare("sample_value", 32'(w.sample), 32'(sample));
            compare("status_code", 32'(w.status), 32'(status));
            compare("rate_hz", w.rate, r_hz);
            compare("total_samples", 32'(w.total), 32'(total));
            compare("end_of_run", 32'(w.eor), 32'(eor));
            if (kind == KIND_STATUS)
            begin
                statuses_seen++;
                codes_seen[status] = 1'b1;
            end
            else
                samples_seen++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               final_byte;
    logic               out_valid;
    logic               out_stall;
    logic               result_kind;
    logic signed [15:0] sample_value;
    logic [2:0]         status_code;
    logic [31:0]        rate_hz;
    logic [30:0]        total_samples;
    logic               end_of_run;

    wav_parse_predictor sb = new();
    logic [7:0]         file_bytes[$];
    bit                 calm;
    bit                 hold_req;
    int                 bytes_sent;
    int                 files_sent;

    wav_pcm16_mono_stream_parser u_dut (.*);

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // overall time limit
    initial
    begin
        #5ms;
        $display("FAIL wav_pcm16_mono_stream_parser");
        $finish;
    end

    // file building helpers
    function void put_byte(input logic [7:0] v);
        file_bytes.insert(file_bytes.size(), v);
    endfunction

    function void put_le16(input logic [15:0] v);
        put_byte(v[7:0]);
        put_byte(v[15:8]);
    endfunction

    function void put_le32(input logic [31:0] v);
        put_le16(v[15:0]);
        put_le16(v[31:16]);
    endfunction

    function void put_tag(input logic [31:0] t);
        put_byte(t[31:24]);
        put_byte(t[23:16]);
        put_byte(t[15:8]);
        put_byte(t[7:0]);
    endfunction

    function void put_body(input int unsigned n);
        repeat (n) put_byte(8'($urandom));
        if (n % 2 == 1)
            put_byte(8'($urandom));
    endfunction

    function void add_chunk(input logic [31:0] t, input int unsigned n);
        put_tag(t);
        put_le32(n);
        put_body(n);
    endfunction

    function void add_fmt(input logic [15:0] fmt, input logic [15:0] ch,
                          input logic [15:0] bits, input logic [31:0] r_hz);
        int unsigned n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 21) : 16;
        put_tag(TAG_FMT);
        put_le32(n);
        put_le16(fmt);
        put_le16(ch);
        put_le32(r_hz);
        put_le32($urandom);
        put_le16(16'($urandom));
        put_le16(bits);
        put_body(n - 16);
    endfunction

    function logic [31:0] some_rate();
        logic [31:0] r;
        r = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 48000);
        return (r == 32'd0) ? 32'd8000 : r;
    endfunction

    function logic [15:0] wrong_of(input logic [15:0] good);
        logic [15:0] v;
        v = 16'($urandom);
        return (v == good) ? (v ^ 16'h0001) : v;
    endfunction

    function void add_good_fmt();
        add_fmt(FMT_PCM, CH_MONO, BITS_PCM16, some_rate());
    endfunction

    function void build_file(input file_kind_t kind);
        int unsigned idx;
        file_bytes.delete();
        put_tag(TAG_RIFF);
        put_le32($urandom);
        put_tag(TAG_WAVE);
        case (kind)
            FILE_OK, FILE_SMALL, FILE_NOT_RIFF:
            begin
                add_good_fmt();
                add_chunk(TAG_DATA, $urandom_range(2, 24));
                if (kind == FILE_SMALL)
                begin
                    idx = $urandom_range(1, 43);
                    while (file_bytes.size() > idx)
                        void'(file_bytes.pop_back());
                end
                if (kind == FILE_NOT_RIFF)
                begin
                    idx = $urandom_range(0, 7);
                    idx = (idx < 4) ? idx : idx + 4;
                    file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
            FILE_SHORT_FMT:
            begin
                add_chunk(TAG_FMT, $urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1)
                    add_good_fmt();
                add_chunk(TAG_DATA, $urandom_range(0, 12));
            end
            FILE_MISSING:
            begin
                if ($urandom_range(0, 1) == 1)
                    add_good_fmt();
                else
                    add_chunk(TAG_DATA, $urandom_range(2, 12));
            end
            FILE_FORMAT:
            begin
                case ($urandom_range(0, 2))
                    0: add_fmt(wrong_of(FMT_PCM), CH_MONO, BITS_PCM16, some_rate());
                    1: add_fmt(FMT_PCM, wrong_of(CH_MONO), BITS_PCM16, some_rate());
                    default: add_fmt(FMT_PCM, CH_MONO, wrong_of(BITS_PCM16), some_rate());
                endcase
                add_chunk(TAG_DATA, $urandom_range(2, 12));
            end
            FILE_ZERO_RATE:
            begin
                add_fmt(FMT_PCM, CH_MONO, BITS_PCM16, 32'd0);
                add_chunk(TAG_DATA, $urandom_range(2, 12));
            end
            FILE_EMPTY:
            begin
                add_good_fmt();
                add_chunk(TAG_DATA, $urandom_range(0, 1));
            end
            FILE_MULTI:
            begin
                repeat ($urandom_range(2, 5))
                begin
                    case ($urandom_range(0, 4))
                        0: add_good_fmt();
                        1: add_fmt(wrong_of(FMT_PCM), CH_MONO, BITS_PCM16, some_rate());
                        2, 3: add_chunk(TAG_DATA, $urandom_range(0, 15));
                        default: add_chunk(TAG_JUNK, $urandom_range(0, 7));
                    endcase
                end
            end
            FILE_TRUNC:
            begin
                add_good_fmt();
                add_chunk(TAG_DATA, $urandom_range(2, 10));
                put_tag(($urandom_range(0, 1) == 1) ? TAG_DATA : TAG_FMT);
                put_le32($urandom | 32'h0000_0100);
                repeat ($urandom_range(1, 10)) put_byte(8'($urandom));
            end
            default:
            begin
                file_bytes.delete();
                repeat ($urandom_range(1, 70)) put_byte(8'($urandom));
            end
        endcase
        // pad out files meant to pass the size check
        if (kind != FILE_SMALL && kind != FILE_NOISE && file_bytes.size() < 44)
            add_chunk(TAG_JUNK, 44 - file_bytes.size());
    endfunction

    // one input transfer, with random gaps before it
    task automatic send_byte(input logic [7:0] b, input logic fin);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        final_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.accept_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        while (sb.expected_results.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_left = 80;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 14);
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(result_kind, sample_value, status_code, rate_hz,
                                total_samples, end_of_run);
        end
    end

    // input side: reset, directed files, then generated files
    initial
    begin
        int          k;
        int          rnd_bytes;
        int unsigned pick;
        file_kind_t  kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        final_byte = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        bytes_sent = 0;
        files_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: a one-byte file, a bare header, a short run of extreme bytes
        file_bytes = '{8'hFF};
        send_file();
        file_bytes.delete();
        put_tag(TAG_RIFF);
        put_le32(32'h0000_0000);
        put_tag(TAG_WAVE);
        send_file();
        file_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00, 8'hFF};
        send_file();
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained(2000);

        // generated: every file shape once, then a random mix in which well-formed files are the most common shape
        k = 0;
        rnd_bytes = 0;
        while (rnd_bytes < 600)
        begin
            if (k < NUM_FILE_KINDS)
                kind = file_kind_t'(k);
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    kind = FILE_OK;
                else if (pick < 55)
                    kind = FILE_MULTI;
                else if (pick < 63)
                    kind = FILE_TRUNC;
                else
                    kind = file_kind_t'($urandom_range(FILE_SMALL, FILE_NOISE));
            end
            build_file(kind);
            // long output hold-off so the parser backs up into its input
            if (k == 2)
                hold_req = 1'b1;
            calm = (k >= 4 && k <= 6);
            // let everything drain before this file
            if (k == 8)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait_drained(2000);
            end
            rnd_bytes += file_bytes.size();
            send_file();
            k++;
        end
        calm = 1'b0;

        // drain and settle
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained(5000);
        repeat (20) @(posedge clk);
        if (sb.expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $realtime, sb.expected_results.size());
            sb.errors++;
        end
        $display("covered %0d files, %0d bytes: %0d samples and %0d status results",
                 files_sent, bytes_sent, sb.samples_seen, sb.statuses_seen);
        $display("status codes reported (bit per code): %b", sb.codes_seen);
        if (sb.errors == 0)
            $display("PASS wav_pcm16_mono_stream_parser");
        else
            $display("FAIL wav_pcm16_mono_stream_parser");
        $finish;
    end

endmodule
